[hdl/cpt_pkg.sv]
`timescale 1ns / 1ps
// cpt_pkg: widths, saturation limits, status codes and side-band types
// for the circumcircle point test pipeline. No dependencies.
package cpt_pkg;

    localparam int XW       = 32;
    localparam int TOLW     = 16;
    localparam int EW       = XW + 1;
    localparam int PW       = 2 * EW;
    localparam int KW       = PW + 2;
    localparam int KLW      = 34;
    localparam int PPW      = KLW + 1 + EW;
    localparam int NW       = 104;
    localparam int DW       = KW + 2;
    localparam int NUW      = NW + 2;
    localparam int RW       = DW + 1;
    localparam int QW       = XW + 1;
    localparam int VW       = PW + 1;
    localparam int SW       = 36;
    localparam int TW       = 2 * SW + 2;
    localparam int RADW     = XW - 1;
    localparam int STW      = 2;
    localparam int LANES    = 2;
    localparam int LAT      = 9 + QW + 4 + SW + 1;
    localparam int FLAT_DEN = 2;

    localparam logic [TOLW-1:0]     TOL_RESET = TOLW'(1);
    localparam logic [QW-1:0]       NEG_MAG   = QW'(1) << (XW - 1);
    localparam logic [QW-1:0]       POS_MAX   = NEG_MAG - QW'(1);
    localparam logic signed [XW-1:0] C_MIN    = {1'b1, {(XW-1){1'b0}}};
    localparam logic signed [XW-1:0] C_MAX    = {1'b0, {(XW-1){1'b1}}};

    typedef enum logic [STW-1:0] {
        ST_OK     = 2'd0,
        ST_FLAT   = 2'd1,
        ST_COLLIN = 2'd2,
        ST_SAT    = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [XW-1:0] qx;
        logic signed [XW-1:0] qy;
        logic signed [XW-1:0] bx;
        logic signed [XW-1:0] by;
        t_status              spec;
    } t_side;

    typedef struct packed {
        logic signed [XW-1:0] cx;
        logic signed [XW-1:0] cy;
        logic                 sat;
        logic                 in_circ;
        t_status              spec;
    } t_res;

endpackage

[hdl/circumcircle_point_test_top.sv]
`timescale 1ns / 1ps
// circumcircle_point_test_top: pipelined circumcircle point test in Q16.16.
// Depends on cpt_pkg.
//
// One item enters per clock while o_stall is low; its path runs through the
// 33-stage restoring divider that forms both centre coordinates side by side
// and the 36-stage square root for the radius. A stall on the output holds the
// whole pipeline; the pipeline advances whenever no result is held at the output.
// The tolerance register may be written only while no item is in flight.
module circumcircle_point_test_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cpt_pkg::TOLW-1:0]        i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [cpt_pkg::XW-1:0]   i_query_x,
    input  logic signed [cpt_pkg::XW-1:0]   i_query_y,
    input  logic signed [cpt_pkg::XW-1:0]   i_vertex_a_x,
    input  logic signed [cpt_pkg::XW-1:0]   i_vertex_a_y,
    input  logic signed [cpt_pkg::XW-1:0]   i_vertex_b_x,
    input  logic signed [cpt_pkg::XW-1:0]   i_vertex_b_y,
    input  logic signed [cpt_pkg::XW-1:0]   i_vertex_c_x,
    input  logic signed [cpt_pkg::XW-1:0]   i_vertex_c_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_inside_res,
    output logic [cpt_pkg::STW-1:0]         o_status,
    output logic signed [cpt_pkg::XW-1:0]   o_center_x,
    output logic signed [cpt_pkg::XW-1:0]   o_center_y,
    output logic [cpt_pkg::RADW-1:0]        o_radius
);
    import cpt_pkg::*;

    logic            en;
    logic [LAT-1:0]  r_vld;
    logic [TOLW-1:0] r_tol;

    logic signed [XW-1:0] r1_qx, r1_qy, r1_ax, r1_ay, r1_bx, r1_by, r1_cx, r1_cy;

    logic signed [EW-1:0] r2_dx1, r2_dy1, r2_dx2, r2_dy2;
    logic signed [EW-1:0] r2_sx12, r2_sx23, r2_sy12, r2_sy23, r2_dx13;
    t_side                r2_side;

    logic signed [PW-1:0] r3_pda, r3_pdb, r3_k1a, r3_k1b, r3_k2a, r3_k2b;
    logic signed [PW-1:0] r3_f1a, r3_f1b, r3_f2a, r3_f2b;
    logic                 r3_flat1, r3_flat2;
    logic signed [EW-1:0] r3_dx1, r3_dx2, r3_dy1, r3_dy2, r3_sx12, r3_sx23;
    t_side                r3_side;
    logic [EW-1:0]        n_ady1, n_ady2;
    t_status              n_spec;

    logic signed [KW-1:0] r4_det, r4_k1, r4_k2, r4_ny1, r4_ny2, n_det;
    logic                 r4_flat1, r4_flat2;
    logic signed [EW-1:0] r4_dx1, r4_dx2, r4_dy1, r4_dy2, r4_sx12, r4_sx23;
    t_side                r4_side;

    logic signed [PPW-1:0] r5_ah, r5_al, r5_bh, r5_bl, r5_ch, r5_cl, r5_dh, r5_dl;
    logic signed [KW-1:0]  r5_det, r5_ny1, r5_ny2;
    logic                  r5_flat1, r5_flat2;
    logic signed [EW-1:0]  r5_dy1, r5_dy2, r5_sx12, r5_sx23;
    t_side                 r5_side;

    logic signed [NW-1:0] n_nx, n_ny;
    logic signed [NW-1:0] r6_num [LANES];
    logic signed [DW-1:0] r6_den [LANES];
    t_side                r6_side;

    logic [NW-1:0] r7_an [LANES];
    logic [DW-1:0] r7_ad [LANES];
    logic          r7_neg [LANES];
    t_side         r7_side;

    logic [NUW-1:0] r8_nn [LANES];
    logic [RW-1:0]  r8_dd [LANES];
    logic           r8_neg [LANES];
    t_side          r8_side;

    logic [RW-1:0] r_drem [QW+1][LANES];
    logic [RW-1:0] r_dden [QW+1][LANES];
    logic [QW-1:0] r_dnum [QW+1][LANES];
    logic [QW-1:0] r_dquo [QW+1][LANES];
    logic          r_dneg [QW+1][LANES];
    logic          r_dovf [QW+1][LANES];
    t_side         r_dside [QW+1];

    logic signed [XW-1:0] n_c [LANES];
    logic                 n_csat [LANES];
    logic signed [XW-1:0] r_p1_c [LANES];
    logic                 r_p1_sat;
    t_side                r_p1_side;

    logic signed [EW-1:0] r_p2_rx, r_p2_ry, r_p2_qx, r_p2_qy;
    t_res                 r_p2_res;
    logic signed [PW-1:0] r_p3_rx2, r_p3_ry2, r_p3_qx2, r_p3_qy2;
    t_res                 r_p3_res;

    logic [VW-1:0] r_dsq;
    logic [VW-1:0] r_srem [SW+1];
    logic [SW-1:0] r_sres [SW+1];
    t_res          r_sside [SW+1];

    logic          n_rbig;
    logic          r_out_inside;
    t_status       r_out_status;
    logic signed [XW-1:0] r_out_cx, r_out_cy;
    logic [RADW-1:0] r_out_rad;

    // advance everything unless a result is held at the output
    assign en      = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    assign n_ady1 = r2_dy1[EW-1] ? EW'(-r2_dy1) : EW'(r2_dy1);
    assign n_ady2 = r2_dy2[EW-1] ? EW'(-r2_dy2) : EW'(r2_dy2);
    assign n_det  = KW'(r3_pda) - KW'(r3_pdb);
    assign n_spec = (r3_flat1 && r3_flat2) ? ST_FLAT
                  : (!r3_flat1 && !r3_flat2 && n_det == '0) ? ST_COLLIN : r3_side.spec;

    // nx = k2*dy1 - k1*dy2, ny = dx2*k1 - dx1*k2 from split partial products
    assign n_nx = (NW'(r5_ah) <<< KLW) + NW'(r5_al) - (NW'(r5_bh) <<< KLW) - NW'(r5_bl);
    assign n_ny = (NW'(r5_ch) <<< KLW) + NW'(r5_cl) - (NW'(r5_dh) <<< KLW) - NW'(r5_dl);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_qx <= i_query_x;
            r1_qy <= i_query_y;
            r1_ax <= i_vertex_a_x;
            r1_ay <= i_vertex_a_y;
            r1_bx <= i_vertex_b_x;
            r1_by <= i_vertex_b_y;
            r1_cx <= i_vertex_c_x;
            r1_cy <= i_vertex_c_y;

            r2_dx1  <= EW'(r1_bx) - EW'(r1_ax);
            r2_dy1  <= EW'(r1_by) - EW'(r1_ay);
            r2_dx2  <= EW'(r1_cx) - EW'(r1_bx);
            r2_dy2  <= EW'(r1_cy) - EW'(r1_by);
            r2_sx12 <= EW'(r1_ax) + EW'(r1_bx);
            r2_sx23 <= EW'(r1_bx) + EW'(r1_cx);
            r2_sy12 <= EW'(r1_ay) + EW'(r1_by);
            r2_sy23 <= EW'(r1_by) + EW'(r1_cy);
            r2_dx13 <= EW'(r1_ax) - EW'(r1_cx);
            r2_side <= '{qx: r1_qx, qy: r1_qy, bx: r1_bx, by: r1_by, spec: ST_OK};

            r3_pda   <= r2_dx2 * r2_dy1;
            r3_pdb   <= r2_dx1 * r2_dy2;
            r3_k1a   <= r2_dx1 * r2_sx12;
            r3_k1b   <= r2_dy1 * r2_sy12;
            r3_k2a   <= r2_dx2 * r2_sx23;
            r3_k2b   <= r2_dy2 * r2_sy23;
            r3_f1a   <= r2_sy23 * r2_dy2;
            r3_f1b   <= r2_dx2 * r2_dx13;
            r3_f2a   <= r2_sy12 * r2_dy1;
            r3_f2b   <= r2_dx1 * r2_dx13;
            r3_flat1 <= n_ady1 < EW'(r_tol);
            r3_flat2 <= n_ady2 < EW'(r_tol);
            r3_dx1   <= r2_dx1;
            r3_dx2   <= r2_dx2;
            r3_dy1   <= r2_dy1;
            r3_dy2   <= r2_dy2;
            r3_sx12  <= r2_sx12;
            r3_sx23  <= r2_sx23;
            r3_side  <= r2_side;

            r4_det   <= n_det;
            r4_k1    <= KW'(r3_k1a) + KW'(r3_k1b);
            r4_k2    <= KW'(r3_k2a) + KW'(r3_k2b);
            r4_ny1   <= KW'(r3_f1a) - KW'(r3_f1b);
            r4_ny2   <= KW'(r3_f2a) + KW'(r3_f2b);
            r4_flat1 <= r3_flat1;
            r4_flat2 <= r3_flat2;
            r4_dx1   <= r3_dx1;
            r4_dx2   <= r3_dx2;
            r4_dy1   <= r3_dy1;
            r4_dy2   <= r3_dy2;
            r4_sx12  <= r3_sx12;
            r4_sx23  <= r3_sx23;
            r4_side  <= '{qx: r3_side.qx, qy: r3_side.qy, bx: r3_side.bx, by: r3_side.by,
                          spec: n_spec};

            r5_ah    <= $signed(r4_k2[KW-1:KLW]) * r4_dy1;
            r5_al    <= $signed({1'b0, r4_k2[KLW-1:0]}) * r4_dy1;
            r5_bh    <= $signed(r4_k1[KW-1:KLW]) * r4_dy2;
            r5_bl    <= $signed({1'b0, r4_k1[KLW-1:0]}) * r4_dy2;
            r5_ch    <= $signed(r4_k1[KW-1:KLW]) * r4_dx2;
            r5_cl    <= $signed({1'b0, r4_k1[KLW-1:0]}) * r4_dx2;
            r5_dh    <= $signed(r4_k2[KW-1:KLW]) * r4_dx1;
            r5_dl    <= $signed({1'b0, r4_k2[KLW-1:0]}) * r4_dx1;
            r5_det   <= r4_det;
            r5_ny1   <= r4_ny1;
            r5_ny2   <= r4_ny2;
            r5_flat1 <= r4_flat1;
            r5_flat2 <= r4_flat2;
            r5_dy1   <= r4_dy1;
            r5_dy2   <= r4_dy2;
            r5_sx12  <= r4_sx12;
            r5_sx23  <= r4_sx23;
            r5_side  <= r4_side;

            if (r5_flat1) begin
                r6_num[0] <= NW'(r5_sx12);
                r6_den[0] <= DW'(FLAT_DEN);
                r6_num[1] <= NW'(r5_ny1);
                r6_den[1] <= DW'(r5_dy2) <<< 1;
            end else if (r5_flat2) begin
                r6_num[0] <= NW'(r5_sx23);
                r6_den[0] <= DW'(FLAT_DEN);
                r6_num[1] <= NW'(r5_ny2);
                r6_den[1] <= DW'(r5_dy1) <<< 1;
            end else begin
                r6_num[0] <= n_nx;
                r6_den[0] <= DW'(r5_det) <<< 1;
                r6_num[1] <= n_ny;
                r6_den[1] <= DW'(r5_det) <<< 1;
            end
            r6_side <= r5_side;

            for (int l = 0; l < LANES; l++) begin
                r7_an[l]  <= r6_num[l][NW-1] ? -r6_num[l] : r6_num[l];
                r7_ad[l]  <= r6_den[l][DW-1] ? -r6_den[l] : r6_den[l];
                r7_neg[l] <= r6_num[l][NW-1] ^ r6_den[l][DW-1];
                r8_nn[l]  <= (NUW'(r7_an[l]) << 1) + NUW'(r7_ad[l]);
                r8_dd[l]  <= RW'(r7_ad[l]) << 1;
                r8_neg[l] <= r7_neg[l];
                r_drem[0][l] <= r8_nn[l][QW+RW-1:QW];
                r_dden[0][l] <= r8_dd[l];
                r_dnum[0][l] <= r8_nn[l][QW-1:0];
                r_dquo[0][l] <= '0;
                r_dneg[0][l] <= r8_neg[l];
                r_dovf[0][l] <= (r8_nn[l] >> QW) >= NUW'(r8_dd[l]);
            end
            r7_side    <= r6_side;
            r8_side    <= r7_side;
            r_dside[0] <= r8_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [RW:0] n_s;
            logic        n_ge;
            assign n_s  = {r_drem[k-1][l], r_dnum[k-1][l][QW-1]};
            assign n_ge = n_s >= {1'b0, r_dden[k-1][l]};
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_drem[k][l] <= n_ge ? RW'(n_s - {1'b0, r_dden[k-1][l]}) : n_s[RW-1:0];
                    r_dden[k][l] <= r_dden[k-1][l];
                    r_dnum[k][l] <= r_dnum[k-1][l] << 1;
                    r_dquo[k][l] <= {r_dquo[k-1][l][QW-2:0], n_ge};
                    r_dneg[k][l] <= r_dneg[k-1][l];
                    r_dovf[k][l] <= r_dovf[k-1][l];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dside[k] <= r_dside[k-1];
            end
        end
    end

    // round-to-nearest quotient, clamp to the signed 32 bit range
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (r_dneg[QW][l]) begin
                n_csat[l] = r_dovf[QW][l] || (r_dquo[QW][l] > NEG_MAG);
                n_c[l]    = n_csat[l] ? C_MIN : XW'(-r_dquo[QW][l]);
            end else begin
                n_csat[l] = r_dovf[QW][l] || (r_dquo[QW][l] > POS_MAX);
                n_c[l]    = n_csat[l] ? C_MAX : r_dquo[QW][l][XW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_c[0] <= n_c[0];
            r_p1_c[1] <= n_c[1];
            r_p1_sat  <= n_csat[0] || n_csat[1];
            r_p1_side <= r_dside[QW];

            r_p2_rx  <= EW'(r_p1_side.bx) - EW'(r_p1_c[0]);
            r_p2_ry  <= EW'(r_p1_side.by) - EW'(r_p1_c[1]);
            r_p2_qx  <= EW'(r_p1_side.qx) - EW'(r_p1_c[0]);
            r_p2_qy  <= EW'(r_p1_side.qy) - EW'(r_p1_c[1]);
            r_p2_res <= '{cx: r_p1_c[0], cy: r_p1_c[1], sat: r_p1_sat, in_circ: 1'b0,
                          spec: r_p1_side.spec};

            r_p3_rx2 <= r_p2_rx * r_p2_rx;
            r_p3_ry2 <= r_p2_ry * r_p2_ry;
            r_p3_qx2 <= r_p2_qx * r_p2_qx;
            r_p3_qy2 <= r_p2_qy * r_p2_qy;
            r_p3_res <= r_p2_res;

            r_srem[0]  <= VW'(r_p3_rx2) + VW'(r_p3_ry2);
            r_dsq      <= VW'(r_p3_qx2) + VW'(r_p3_qy2);
            r_sres[0]  <= '0;
            r_sside[0] <= r_p3_res;
        end
    end

    for (genvar k = 1; k <= SW; k++) begin : g_sqrt
        localparam int B = SW - k;
        logic [TW-1:0] n_t;
        logic          n_ge;
        assign n_t  = (TW'(r_sres[k-1]) << (B + 1)) | (TW'(1) << (2 * B));
        assign n_ge = TW'(r_srem[k-1]) >= n_t;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srem[k]  <= n_ge ? VW'(TW'(r_srem[k-1]) - n_t) : r_srem[k-1];
                r_sres[k]  <= n_ge ? (r_sres[k-1] | (SW'(1) << B)) : r_sres[k-1];
                if (k == 1) begin
                    r_sside[k] <= '{cx: r_sside[0].cx, cy: r_sside[0].cy,
                                    sat: r_sside[0].sat, in_circ: r_dsq <= r_srem[0],
                                    spec: r_sside[0].spec};
                end else begin
                    r_sside[k] <= r_sside[k-1];
                end
            end
        end
    end

    assign n_rbig = |r_sres[SW][SW-1:RADW];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_sside[SW].spec != ST_OK) begin
                r_out_inside <= 1'b0;
                r_out_status <= r_sside[SW].spec;
                r_out_cx     <= '0;
                r_out_cy     <= '0;
                r_out_rad    <= '0;
            end else begin
                r_out_inside <= r_sside[SW].in_circ;
                r_out_status <= (r_sside[SW].sat || n_rbig) ? ST_SAT : ST_OK;
                r_out_cx     <= r_sside[SW].cx;
                r_out_cy     <= r_sside[SW].cy;
                r_out_rad    <= n_rbig ? '1 : r_sres[SW][RADW-1:0];
            end
        end
    end

    assign o_inside_res = r_out_inside;
    assign o_status     = r_out_status;
    assign o_center_x   = r_out_cx;
    assign o_center_y   = r_out_cy;
    assign o_radius     = r_out_rad;

    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FLAT || o_status == ST_COLLIN) |->
            !o_inside_res && o_center_x == '0 && o_center_y == '0 && o_radius == '0)
        else $error("special status with nonzero result");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_radius) && $stable(o_status))
        else $error("held result changed");

endmodule
